// File: rtl/cfe_pkg.sv
`default_nettype none
package cfe_pkg;

	localparam int BYTE_W = 8;
	localparam int IDX_W  = 5;
	localparam int VAL_W  = 16;

	// controller to datapath
	typedef struct packed {
		logic load;        // input transaction accepted
		logic advance;     // result transaction accepted, move snapshot on
		logic word_phase;  // current result is a word field
	} cfe_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;         // accepted byte completes the first valid frame
	} cfe_status_t;

endpackage
`default_nettype wire

// File: rtl/checksummed_frame_extractor.sv
// latency: first result is offered the cycle after the input transaction that completes a frame
// throughput: one byte per cycle when no frame is found; a found frame holds the input until
//   all WORD_FIELDS + BYTE_FIELDS results (29 by default) are accepted, as counted by the field counter
// reset: arst_n asynchronous active low; clears window, running sum, fill count, taken flag,
//   start marker and controller; no clearing pass is needed
`default_nettype none
module checksummed_frame_extractor #(
	parameter int FRAME_BYTES = 48,
	parameter int WORD_FIELDS = 16,
	parameter int BYTE_FIELDS = 13
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration: start marker
	input  wire logic                        cfg_wr_en,
	input  wire logic [cfe_pkg::BYTE_W-1:0]  cfg_wr_data,
	// input channel
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [cfe_pkg::BYTE_W-1:0]  data_byte,
	input  wire logic                        buffer_end,
	// result channel
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [cfe_pkg::IDX_W-1:0]   field_index,
	output logic      [cfe_pkg::VAL_W-1:0]   field_value,
	output logic                             last_field
);
	import cfe_pkg::*;

	cfe_cmd_t    cmd;
	cfe_status_t status;

	// sequencer: idles taking bytes, then walks the field counter over one frame
	cfe_control #(
		.WORD_FIELDS (WORD_FIELDS),
		.BYTE_FIELDS (BYTE_FIELDS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.field_index (field_index),
		.last_field  (last_field),
		.status      (status),
		.cmd         (cmd)
	);

	// sliding window, running sum, frame check and the snapshot that feeds the results
	cfe_datapath #(
		.FRAME_BYTES (FRAME_BYTES),
		.WORD_FIELDS (WORD_FIELDS),
		.BYTE_FIELDS (BYTE_FIELDS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.data_byte   (data_byte),
		.buffer_end  (buffer_end),
		.cmd         (cmd),
		.status      (status),
		.field_value (field_value)
	);

endmodule
`default_nettype wire

// File: rtl/cfe_datapath.sv
`default_nettype none
module cfe_datapath #(
	parameter int FRAME_BYTES = 48,
	parameter int WORD_FIELDS = 16,
	parameter int BYTE_FIELDS = 13
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [cfe_pkg::BYTE_W-1:0]    cfg_wr_data,
	input  wire logic [cfe_pkg::BYTE_W-1:0]    data_byte,
	input  wire logic                          buffer_end,
	input  wire cfe_pkg::cfe_cmd_t             cmd,
	output cfe_pkg::cfe_status_t               status,
	output logic      [cfe_pkg::VAL_W-1:0]     field_value
);
	import cfe_pkg::*;

	localparam int FILL_W   = $clog2(FRAME_BYTES + 1);
	localparam int SNAP_LEN = 2 * WORD_FIELDS + 1 + BYTE_FIELDS;

	logic [BYTE_W-1:0] marker_q;
	logic [BYTE_W-1:0] win_q    [FRAME_BYTES];
	logic [BYTE_W-1:0] win_next [FRAME_BYTES];
	logic [BYTE_W-1:0] snap_q   [SNAP_LEN];
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] sum_next;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_next;
	logic              taken_q;

	// window after the incoming byte is shifted in
	always_comb begin
		for (int j = 0; j < FRAME_BYTES - 1; j++) begin
			win_next[j] = win_q[j + 1];
		end
		win_next[FRAME_BYTES-1] = data_byte;
	end

	assign sum_next  = sum_q - win_q[0] + win_q[FRAME_BYTES-1];
	assign fill_next = (fill_q == FILL_W'(FRAME_BYTES)) ? fill_q : fill_q + FILL_W'(1);

	assign status.hit = (fill_next == FILL_W'(FRAME_BYTES)) && !taken_q &&
		(win_next[0] == marker_q) && (sum_next == data_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= '0;
		end else if (cfg_wr_en) begin
			marker_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < FRAME_BYTES; j++) begin
				win_q[j] <= '0;
			end
			sum_q   <= '0;
			fill_q  <= '0;
			taken_q <= 1'b0;
		end else if (cmd.load) begin
			if (buffer_end) begin
				for (int j = 0; j < FRAME_BYTES; j++) begin
					win_q[j] <= '0;
				end
				sum_q   <= '0;
				fill_q  <= '0;
				taken_q <= 1'b0;
			end else begin
				for (int j = 0; j < FRAME_BYTES; j++) begin
					win_q[j] <= win_next[j];
				end
				sum_q   <= sum_next;
				fill_q  <= fill_next;
				taken_q <= taken_q | status.hit;
			end
		end
	end

	// snapshot of window bytes 1 onwards; words leave two bytes at a time
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < SNAP_LEN; i++) begin
				snap_q[i] <= win_next[i + 1];
			end
		end else if (cmd.advance) begin
			if (cmd.word_phase) begin
				for (int i = 0; i < SNAP_LEN - 2; i++) begin
					snap_q[i] <= snap_q[i + 2];
				end
			end else begin
				for (int i = 0; i < SNAP_LEN - 1; i++) begin
					snap_q[i] <= snap_q[i + 1];
				end
			end
		end
	end

	assign field_value = cmd.word_phase ? {snap_q[0], snap_q[1]}
		: {{(VAL_W-BYTE_W){1'b0}}, snap_q[1]};

endmodule
`default_nettype wire

// File: rtl/cfe_control.sv
`default_nettype none
module cfe_control #(
	parameter int WORD_FIELDS = 16,
	parameter int BYTE_FIELDS = 13
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [cfe_pkg::IDX_W-1:0]   field_index,
	output logic                             last_field,
	input  wire cfe_pkg::cfe_status_t        status,
	output cfe_pkg::cfe_cmd_t                cmd
);
	import cfe_pkg::*;

	localparam int NUM_FIELDS = WORD_FIELDS + BYTE_FIELDS;
	localparam int CNT_W      = $clog2(NUM_FIELDS);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             in_acc;
	logic             out_acc;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;

	assign field_index = IDX_W'(cnt_q);
	assign last_field  = (cnt_q == CNT_W'(NUM_FIELDS - 1));

	assign cmd.load       = in_acc;
	assign cmd.advance    = out_acc;
	assign cmd.word_phase = (cnt_q < CNT_W'(WORD_FIELDS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc && status.hit) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						if (last_field) begin
							state_q <= ST_IDLE;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/cfe_checker.sv
`default_nettype none
module cfe_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic [cfe_pkg::IDX_W-1:0]   field_index,
	input wire logic                        last_field
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// no input transaction while a frame is being emitted
	a_in_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open during emission");

	// fields of one frame follow in order
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_field |=>
			out_valid && field_index == $past(field_index) + 5'd1)
		else $error("field index out of sequence");

	// emission stops after the last field
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_field |=> !out_valid)
		else $error("result after last field");

	// a frame always starts at field zero
	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid || field_index == 5'd0)
		else $error("frame did not start at field zero");

endmodule

bind checksummed_frame_extractor cfe_checker u_cfe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.field_index (field_index),
	.last_field  (last_field)
);
`default_nettype wire
